### rtl/windowed_envelope_gate_top_defines.svh
// assertion macros for the windowed envelope gate
`ifndef WINDOWED_ENVELOPE_GATE_TOP_DEFINES_SVH
`define WINDOWED_ENVELOPE_GATE_TOP_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define WEG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WEG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/weg_pkg.sv
// shared constants and types for the windowed envelope gate
`timescale 1ns / 1ps

package weg_pkg;

    // window store depth and derived widths
    localparam int WINDOW_MAX = 512;
    localparam int POS_W      = $clog2(WINDOW_MAX);
    localparam int WL_W       = 10;
    localparam int LEN_W      = (POS_W + 1 > WL_W) ? POS_W + 1 : WL_W;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int THR_W    = 24;
    localparam int COEF_W   = 16;
    localparam int ENV_W    = 24;
    localparam int PROD_W   = COEF_W + ENV_W;
    localparam int CFG_W    = 24;

    // register reset values
    localparam logic [WL_W-1:0]   WL_RESET    = WL_W'(480);
    localparam logic [THR_W-1:0]  THR_RESET   = THR_W'(83886);
    localparam logic [COEF_W-1:0] RISE_RESET  = COEF_W'(65000);
    localparam logic [COEF_W-1:0] FALL_RESET  = COEF_W'(6554);
    // -90 dB floor used when the threshold is zero
    localparam logic [THR_W-1:0]  THR_FLOOR   = THR_W'(265);

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_WINDOW_LENGTH = 2'd0,
        CFG_THRESHOLD     = 2'd1,
        CFG_RISE_COEF     = 2'd2,
        CFG_FALL_COEF     = 2'd3
    } weg_cfg_idx_t;

    typedef logic [POS_W-1:0]           weg_addr_t;
    typedef logic signed [SAMPLE_W-1:0] weg_sample_t;

    // store access for one item: write and read issued in the same cycle
    typedef struct packed {
        logic        we;
        weg_addr_t   waddr;
        weg_sample_t wleft;
        weg_sample_t wright;
        logic        re;
        weg_addr_t   raddr;
    } weg_store_req_t;

endpackage

### rtl/windowed_envelope_gate_top.sv
// windowed envelope gate: look-ahead noise gate over a stereo stream
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  tdata {right_in, left_in}, tuser armed
//  m_       out  m_tvalid/m_tready  tdata {right_out, left_out}
//  cfg_     in   cfg_wr_en          cfg_addr index, cfg_wr_data value
//
// one item per cycle sustained while the output is not stalled; the window
// state is updated in the accept cycle, the store read returns in the next
// cycle and the result moves into the output register once that is free.
// reset needs no clearing pass: store entries are written before read.
// a stalled output holds the middle stage, which then holds off input.
`timescale 1ns / 1ps
`include "windowed_envelope_gate_top_defines.svh"

module windowed_envelope_gate_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,     // left_in [23:0], right_in [47:24]
    input  logic [0:0]  s_tuser,     // armed [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // left_out [23:0], right_out [47:24]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [23:0] cfg_wr_data
);

    localparam int POS_W    = weg_pkg::POS_W;
    localparam int LEN_W    = weg_pkg::LEN_W;
    localparam int ENV_W    = weg_pkg::ENV_W;
    localparam int COEF_W   = weg_pkg::COEF_W;
    localparam int PROD_W   = weg_pkg::PROD_W;
    localparam int SAMPLE_W = weg_pkg::SAMPLE_W;

    // configuration registers
    logic [weg_pkg::WL_W-1:0]  wlen_reg;
    logic [weg_pkg::THR_W-1:0] thr_reg;
    logic [COEF_W-1:0]         rise_reg;
    logic [COEF_W-1:0]         fall_reg;

    // window state
    logic [POS_W-1:0] wp_reg, wp_next;
    logic [POS_W-1:0] rp_reg, rp_next;
    logic [ENV_W-1:0] env_reg, env_next;
    logic             armed_before_reg;
    logic             gate_reg, gate_next;
    logic             pend_reg, pend_next;
    logic             closing_reg, closing_next;

    // pipeline
    logic                 s1_valid_reg, s1_pass_reg;
    logic                 m_valid_reg;
    weg_pkg::weg_sample_t m_left_reg, m_right_reg;
    weg_pkg::weg_sample_t rd_left, rd_right;
    weg_pkg::weg_store_req_t store_req;

    logic out_free, s1_move, accept;

    // per-item datapath
    weg_pkg::weg_sample_t in_left, in_right, in_max;
    logic                 armed;
    logic                 arm_rise, arm_fall;
    logic [LEN_W-1:0]     wl_ext, len;
    logic [LEN_W-1:0]     rp_inc, wp_inc;
    logic [ENV_W-1:0]     mag, env_diff, env_corr, env_upd;
    logic [COEF_W-1:0]    coef;
    logic [PROD_W-1:0]    prod;
    logic [weg_pkg::THR_W-1:0] thr_eff;
    logic                 env_ge;
    logic                 g0, pend0, closing0;
    logic [POS_W-1:0]     wp0, rp0;
    logic [ENV_W-1:0]     env0;
    logic                 rp_wrap, closing1;
    logic                 do_write;

    // handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign accept   = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg <= weg_pkg::WL_RESET;
            thr_reg  <= weg_pkg::THR_RESET;
            rise_reg <= weg_pkg::RISE_RESET;
            fall_reg <= weg_pkg::FALL_RESET;
        end else if (cfg_wr_en) begin
            unique case (weg_pkg::weg_cfg_idx_t'(cfg_addr))
                weg_pkg::CFG_WINDOW_LENGTH: wlen_reg <= cfg_wr_data[weg_pkg::WL_W-1:0];
                weg_pkg::CFG_THRESHOLD:     thr_reg  <= cfg_wr_data[weg_pkg::THR_W-1:0];
                weg_pkg::CFG_RISE_COEF:     rise_reg <= cfg_wr_data[COEF_W-1:0];
                weg_pkg::CFG_FALL_COEF:     fall_reg <= cfg_wr_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // effective window length and threshold
    assign wl_ext  = LEN_W'(wlen_reg);
    assign len     = (wl_ext == '0) ? LEN_W'(1)
                   : (wl_ext > LEN_W'(weg_pkg::WINDOW_MAX)) ? LEN_W'(weg_pkg::WINDOW_MAX)
                   : wl_ext;
    assign thr_eff = (thr_reg == '0) ? weg_pkg::THR_FLOOR : thr_reg;

    // input fields
    assign in_left  = s_tdata[SAMPLE_W-1:0];
    assign in_right = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign armed    = s_tuser[0];
    assign arm_rise = armed && !armed_before_reg;
    assign arm_fall = !armed && armed_before_reg;

    // state after arm edges
    assign g0       = arm_rise ? 1'b0 : gate_reg;
    assign wp0      = arm_rise ? '0 : wp_reg;
    assign rp0      = arm_rise ? '0 : rp_reg;
    assign env0     = arm_rise ? '0 : env_reg;
    assign pend0    = arm_rise ? 1'b0 : (arm_fall ? gate_reg : pend_reg);
    assign closing0 = arm_rise ? 1'b0 : closing_reg;

    // envelope follower on the larger sample
    assign in_max   = (in_left > in_right) ? in_left : in_right;
    assign mag      = in_max[SAMPLE_W-1] ? ENV_W'(~in_max + 1'b1) : ENV_W'(in_max);
    assign env_ge   = env0 >= mag;
    assign coef     = env_ge ? fall_reg : rise_reg;
    assign env_diff = env_ge ? (env0 - mag) : (mag - env0);
    assign prod     = PROD_W'(coef) * PROD_W'(env_diff);
    assign env_corr = prod[PROD_W-1:COEF_W];
    assign env_upd  = env_ge ? (mag + env_corr) : (mag - env_corr);

    assign rp_inc = LEN_W'(rp0) + LEN_W'(1);
    assign wp_inc = LEN_W'(wp0) + LEN_W'(1);

    // next window state for an accepted item
    always_comb begin
        gate_next    = g0;
        pend_next    = pend0;
        closing_next = closing0;
        rp_next      = rp0;
        wp_next      = wp0;
        env_next     = env0;
        // playback side
        if (g0) begin
            rp_next = rp_inc[POS_W-1:0];
            if (rp_inc >= len) begin
                rp_next = '0;
                if (closing0) begin
                    gate_next    = 1'b0;
                    closing_next = 1'b0;
                end else if (pend0) begin
                    closing_next = 1'b1;
                    pend_next    = 1'b0;
                end
            end
        end
        // capture side
        if (do_write) begin
            env_next = env_upd;
            wp_next  = wp_inc[POS_W-1:0];
            if (wp_inc >= len) begin
                if (env_upd != '0 && env_upd >= thr_eff) begin
                    rp_next   = '0;
                    gate_next = 1'b1;
                end
                env_next = '0;
                wp_next  = '0;
            end
        end
    end

    // closing flag once playback has advanced
    assign rp_wrap  = g0 && (rp_inc >= len);
    assign closing1 = rp_wrap ? (!closing0 && pend0) : closing0;
    assign do_write = armed || closing1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg           <= '0;
            rp_reg           <= '0;
            env_reg          <= '0;
            armed_before_reg <= 1'b0;
            gate_reg         <= 1'b0;
            pend_reg         <= 1'b0;
            closing_reg      <= 1'b0;
        end else if (accept) begin
            wp_reg           <= wp_next;
            rp_reg           <= rp_next;
            env_reg          <= env_next;
            armed_before_reg <= armed;
            gate_reg         <= gate_next;
            pend_reg         <= pend_next;
            closing_reg      <= closing_next;
        end
    end

    // store access
    always_comb begin
        store_req.we     = accept && do_write;
        store_req.waddr  = wp0;
        store_req.wleft  = in_left;
        store_req.wright = in_right;
        store_req.re     = accept;
        store_req.raddr  = rp0;
    end

    weg_store u_store (
        .aclk     (aclk),
        .req      (store_req),
        .rd_left  (rd_left),
        .rd_right (rd_right)
    );

    // read stage: waits for store data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pass_reg <= g0;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            m_left_reg  <= s1_pass_reg ? rd_left  : '0;
            m_right_reg <= s1_pass_reg ? rd_right : '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_right_reg, m_left_reg};

    // checks
    `WEG_ASSERT_NEXT(a_stage_holds, aclk, aresetn, s1_valid_reg && !out_free, s1_valid_reg, "read stage item dropped under stall")
    `WEG_ASSERT_NEXT(a_closed_zero, aclk, aresetn, s1_move && !s1_pass_reg, m_left_reg == '0 && m_right_reg == '0, "closed gate produced nonzero item")
    `WEG_ASSERT_SAME(a_closing_open, aclk, aresetn, closing_reg, gate_reg, "closing pass with gate closed")

endmodule

### rtl/weg_store.sv
// two-channel window store, one write and one registered read per cycle
`timescale 1ns / 1ps

module weg_store (
    input  logic                   aclk,
    input  weg_pkg::weg_store_req_t req,
    output weg_pkg::weg_sample_t   rd_left,
    output weg_pkg::weg_sample_t   rd_right
);

    weg_pkg::weg_sample_t left_mem  [weg_pkg::WINDOW_MAX];
    weg_pkg::weg_sample_t right_mem [weg_pkg::WINDOW_MAX];
    weg_pkg::weg_sample_t rd_left_reg;
    weg_pkg::weg_sample_t rd_right_reg;

    // read-first: a read of the entry being written sees the old value
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rd_left_reg  <= left_mem[req.raddr];
            rd_right_reg <= right_mem[req.raddr];
        end
        if (req.we) begin
            left_mem[req.waddr]  <= req.wleft;
            right_mem[req.waddr] <= req.wright;
        end
    end

    assign rd_left  = rd_left_reg;
    assign rd_right = rd_right_reg;

endmodule

### bench/tb_top.sv
// self-checking testbench for the windowed envelope gate: directed and random stereo items
`timescale 1ns / 1ps

module tb_top;

    localparam logic signed [23:0] SAMPLE_MIN = 24'sh800000;
    localparam logic signed [23:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam int unsigned        ITEM_TARGET = 1450;
    localparam int unsigned        DRAIN_CYCLES = 6;

    typedef struct {
        logic signed [23:0] left;
        logic signed [23:0] right;
        logic               armed;
    } stereo_item_t;

    typedef struct {
        logic [23:0] left;
        logic [23:0] right;
    } gated_pair_t;

    // block ports, all inputs known from time zero
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;      // left_in [23:0], right_in [47:24]
    logic [0:0]  s_tuser = '0;      // armed [0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // left_out [23:0], right_out [47:24]
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [23:0] cfg_wr_data = '0;

    stereo_item_t pending_items[$];
    gated_pair_t  expected_pairs[$];
    int unsigned  items_queued = 0;
    int unsigned  items_taken = 0;
    int unsigned  mismatch_count = 0;

    // gate state as the block should hold it
    logic [9:0]  window_reg = weg_pkg::WL_RESET;
    logic [23:0] threshold_reg = weg_pkg::THR_RESET;
    logic [15:0] rise_reg = weg_pkg::RISE_RESET;
    logic [15:0] fall_reg = weg_pkg::FALL_RESET;
    logic [23:0] left_mem [weg_pkg::WINDOW_MAX];
    logic [23:0] right_mem [weg_pkg::WINDOW_MAX];
    logic [9:0]  wr_pos = '0;
    logic [9:0]  rd_pos = '0;
    logic [23:0] env_level = '0;
    logic        was_armed = 1'b0;
    logic        gate_open = 1'b0;
    logic        close_pending = 1'b0;
    logic        closing_pass = 1'b0;

    windowed_envelope_gate_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // window length as the block applies it
    function automatic logic [9:0] window_span(logic [9:0] wl);
        if (wl == 0) return 10'd1;
        if (wl > weg_pkg::WINDOW_MAX) return 10'(weg_pkg::WINDOW_MAX);
        return wl;
    endfunction

    // one step of the gate: update state, return the delayed or muted pair
    function automatic gated_pair_t predict_gate_output(logic signed [23:0] l,
                                                        logic signed [23:0] r,
                                                        logic armed);
        logic [9:0]         span;
        logic signed [23:0] peak;
        logic [23:0]        mag;
        logic [23:0]        diff;
        logic [23:0]        thr;
        logic [15:0]        k;
        logic [39:0]        prod;
        gated_pair_t        pair;
        span = window_span(window_reg);
        pair.left = '0;
        pair.right = '0;
        // arming edge restarts detection, disarming schedules the close
        if (armed && !was_armed) begin
            gate_open = 1'b0;
            wr_pos = '0;
            rd_pos = '0;
            env_level = '0;
            close_pending = 1'b0;
            closing_pass = 1'b0;
        end else if (!armed && was_armed) begin
            close_pending = gate_open;
        end
        was_armed = armed;
        // playback of the previous window
        if (gate_open) begin
            pair.left = left_mem[rd_pos[8:0]];
            pair.right = right_mem[rd_pos[8:0]];
            rd_pos = rd_pos + 1'b1;
            if (rd_pos >= span) begin
                rd_pos = '0;
                if (closing_pass) begin
                    gate_open = 1'b0;
                    closing_pass = 1'b0;
                end else if (close_pending) begin
                    closing_pass = 1'b1;
                    close_pending = 1'b0;
                end
            end
        end
        // capture and envelope tracking
        if (armed || closing_pass) begin
            peak = (l > r) ? l : r;
            mag = peak[23] ? -peak : peak;
            k = (mag > env_level) ? rise_reg : fall_reg;
            left_mem[wr_pos[8:0]] = l;
            right_mem[wr_pos[8:0]] = r;
            if (env_level >= mag) begin
                diff = env_level - mag;
                prod = 40'(k) * 40'(diff);
                env_level = mag + prod[39:16];
            end else begin
                diff = mag - env_level;
                prod = 40'(k) * 40'(diff);
                env_level = mag - prod[39:16];
            end
            wr_pos = wr_pos + 1'b1;
            if (wr_pos >= span) begin
                thr = (threshold_reg == 0) ? weg_pkg::THR_FLOOR : threshold_reg;
                if (env_level != 0 && env_level >= thr) begin
                    rd_pos = '0;
                    gate_open = 1'b1;
                end
                env_level = '0;
                wr_pos = '0;
            end
        end
        return pair;
    endfunction

    // random idling, with one long stretch free of idling
    function automatic bit take_gap();
        if (items_taken >= 700 && items_taken < 950) return 1'b0;
        return $urandom_range(0, 99) < 35;
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    // input driver
    always @(posedge aclk) begin : drive_items
        stereo_item_t item_now;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pairs.push_back(
                    predict_gate_output(s_tdata[23:0], s_tdata[47:24], s_tuser[0]));
                items_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_items.size() != 0 && !take_gap()) begin
                    item_now = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {item_now.right, item_now.left};
                    s_tuser <= item_now.armed;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : watch_results
        gated_pair_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pairs.size() == 0) begin
                    report_mismatch($sformatf("unexpected item %h", m_tdata));
                end else begin
                    want = expected_pairs.pop_front();
                    if (m_tdata[23:0] !== want.left)
                        report_mismatch($sformatf("left_out %h, want %h",
                                                  m_tdata[23:0], want.left));
                    if (m_tdata[47:24] !== want.right)
                        report_mismatch($sformatf("right_out %h, want %h",
                                                  m_tdata[47:24], want.right));
                end
            end
            m_tready <= !take_gap();
        end
    end

    task automatic push_item(logic signed [23:0] l, logic signed [23:0] r, logic armed);
        stereo_item_t it;
        it.left = l;
        it.right = r;
        it.armed = armed;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // random sample confined to about +/- 2^bits
    function automatic logic signed [23:0] scaled_sample(int unsigned bits);
        logic signed [23:0] v;
        v = 24'($urandom);
        return v >>> (23 - bits);
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_items.size() != 0 || s_tvalid || expected_pairs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(weg_pkg::weg_cfg_idx_t idx, logic [23:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= value;
        case (idx)
            weg_pkg::CFG_WINDOW_LENGTH: window_reg = value[9:0];
            weg_pkg::CFG_THRESHOLD:     threshold_reg = value;
            weg_pkg::CFG_RISE_COEF:     rise_reg = value[15:0];
            weg_pkg::CFG_FALL_COEF:     fall_reg = value[15:0];
            default: ;
        endcase
    endtask

    // new settings once the block has drained
    task automatic configure(logic [9:0] wl, logic [23:0] thr, logic [15:0] rise,
                             logic [15:0] fall);
        wait_idle();
        write_reg(weg_pkg::CFG_WINDOW_LENGTH, 24'(wl));
        write_reg(weg_pkg::CFG_THRESHOLD, thr);
        write_reg(weg_pkg::CFG_RISE_COEF, 24'(rise));
        write_reg(weg_pkg::CFG_FALL_COEF, 24'(fall));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // armed runs of whole windows, at times plus part of one, with random level, plus short glitches
    task automatic queue_random_phase(int unsigned count);
        int unsigned span;
        int unsigned run;
        int unsigned bits;
        int unsigned n;
        logic        armed_now;
        span = 32'(window_span(window_reg));
        armed_now = 1'($urandom_range(0, 1));
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 99) < 15)
                run = $urandom_range(1, 2);
            else if (armed_now)
                run = span * $urandom_range(1, 3)
                    + (($urandom_range(0, 3) == 0) ? $urandom_range(0, span) : 0);
            else
                run = span * $urandom_range(0, 2) + $urandom_range(1, 3);
            bits = ($urandom_range(0, 9) == 0) ? 23 : $urandom_range(0, 23);
            for (int unsigned j = 0; j < run && n < count; j++) begin
                push_item(scaled_sample(bits), scaled_sample(bits), armed_now);
                n++;
            end
            armed_now = !armed_now;
        end
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [9:0]  wl;
        logic [23:0] thr;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // window of one (length zero), threshold floor, instant rise
        configure(10'd0, 24'd0, 16'h0000, 16'hFFFF);
        push_item(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        push_item(SAMPLE_MAX, -24'sd1, 1'b1);
        push_item(24'sd0, 24'sd0, 1'b1);
        push_item(-24'sd1, 24'sd1, 1'b0);        // disarm while open
        push_item(24'sd100, 24'sd200, 1'b0);     // closing window
        push_item(24'sd5, 24'sd5, 1'b0);
        push_item(24'sd300, -24'sd300, 1'b1);
        push_item(-24'sd300, 24'sd299, 1'b1);
        push_item(24'sd1, 24'sd2, 1'b0);
        push_item(24'sd7, 24'sd8, 1'b1);         // re-arm during the closing pass
        push_item(24'sd264, 24'sd265, 1'b1);     // envelope right at the floor
        push_item(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        push_item(24'sd0, 24'sd0, 1'b0);

        // window of three, full scale threshold
        configure(10'd3, 24'h800000, 16'h0000, 16'hFFFF);
        push_item(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        push_item(24'sd0, 24'sd0, 1'b1);
        push_item(SAMPLE_MIN, SAMPLE_MIN, 1'b1);
        push_item(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        push_item(24'sd1, -24'sd1, 1'b1);
        push_item(-24'sd5, -24'sd6, 1'b1);
        push_item(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        push_item(-24'sd1, -24'sd1, 1'b0);
        push_item(24'sd123456, -24'sd654321, 1'b0);
        push_item(24'sd0, 24'sd0, 1'b0);
        push_item(24'sd42, -24'sd42, 1'b0);
        push_item(SAMPLE_MIN, SAMPLE_MAX, 1'b0);

        // oversized length acts as the full store; one armed window fills every entry
        configure(10'd1023, 24'd1, 16'hFFFF, 16'h0000);
        for (int i = 0; i < weg_pkg::WINDOW_MAX; i++)
            push_item(scaled_sample(23), scaled_sample(23), 1'b1);

        // random settings, state carried from phase to phase
        while (items_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0:       wl = 10'd0;
                1:       wl = 10'($urandom_range(500, 1023));
                2:       wl = 10'($urandom_range(17, 64));
                default: wl = 10'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 19))
                0:       thr = 24'd0;
                1:       thr = 24'h800000;
                default: thr = 24'($urandom_range(1, 1 << $urandom_range(0, 23)));
            endcase
            configure(wl, thr, pick_coef(), pick_coef());
            queue_random_phase(window_span(wl) > 64 ? $urandom_range(60, 120)
                                                    : $urandom_range(40, 100));
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
